// File: sv/eapm_pkg.sv
// eapm_pkg: shared types, constants, the CORDIC arctangent table and the Q14
// round/saturate helper for the Euler angle to pose matrix unit. No dependencies.
package eapm_pkg;

  localparam int Steps = 20;
  localparam int CW = 24;
  localparam logic signed [CW-1:0] PiQ20 = 24'sd3294199;
  localparam logic signed [CW-1:0] HalfPiQ20 = 24'sd1647099;
  localparam logic signed [CW-1:0] GainQ20 = 24'sd636751;
  localparam logic signed [15:0] OneQ14 = 16'sd16384;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic signed [15:0] yaw_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] roll_angle;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
  } pose_in_t;

  function automatic logic signed [CW-1:0] atan_q20(input logic [4:0] i);
    case (i)
      5'd0:  atan_q20 = 24'sd823550;
      5'd1:  atan_q20 = 24'sd486170;
      5'd2:  atan_q20 = 24'sd256879;
      5'd3:  atan_q20 = 24'sd130396;
      5'd4:  atan_q20 = 24'sd65451;
      5'd5:  atan_q20 = 24'sd32757;
      5'd6:  atan_q20 = 24'sd16383;
      5'd7:  atan_q20 = 24'sd8192;
      5'd8:  atan_q20 = 24'sd4096;
      5'd9:  atan_q20 = 24'sd2048;
      5'd10: atan_q20 = 24'sd1024;
      5'd11: atan_q20 = 24'sd512;
      5'd12: atan_q20 = 24'sd256;
      5'd13: atan_q20 = 24'sd128;
      5'd14: atan_q20 = 24'sd64;
      5'd15: atan_q20 = 24'sd32;
      5'd16: atan_q20 = 24'sd16;
      5'd17: atan_q20 = 24'sd8;
      5'd18: atan_q20 = 24'sd4;
      5'd19: atan_q20 = 24'sd2;
      default: atan_q20 = '0;
    endcase
  endfunction

  function automatic logic signed [15:0] to_q14(input logic signed [47:0] v);
    logic signed [47:0] r;
    r = (v + 48'sd33554432) >>> 26;
    if (r > 48'sd16384) to_q14 = OneQ14;
    else if (r < -48'sd16384) to_q14 = -OneQ14;
    else to_q14 = r[15:0];
  endfunction

endpackage

// File: sv/euler_angles_to_pose_matrix_unit.sv
// Top level: Euler XYZ angles to rotation matrix plus translation.
// Path to m_tvalid: range reduction, 20 CORDIC steps, sign fix,
// two product stages, round/saturate, then the output buffer.
// Throughput: one word per cycle (fully pipelined CORDIC) when m_tready is high.
// Reset: rst synchronous, active high, empties queue, pipeline and buffer.
module euler_angles_to_pose_matrix_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [143:0] s_tdata,  // yaw, pitch, roll (16 each), trans_x/y/z (32 each)
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [239:0] m_tdata   // rot_00..rot_22 (16 each), out_x/y/z (32 each)
);
  eapm_pkg::pose_in_t in_w, q_w;
  logic q_valid, q_ready;
  logic [143:0] rot;
  logic [95:0] trans;

  assign in_w.yaw_angle   = s_tdata[15:0];
  assign in_w.pitch_angle = s_tdata[31:16];
  assign in_w.roll_angle  = s_tdata[47:32];
  assign in_w.trans_x     = s_tdata[79:48];
  assign in_w.trans_y     = s_tdata[111:80];
  assign in_w.trans_z     = s_tdata[143:112];

  eapm_fifo u_fifo (
    .clk, .rst,
    .in_valid(s_tvalid), .in_ready(s_tready), .in_data(in_w),
    .out_valid(q_valid), .out_ready(q_ready), .out_data(q_w)
  );

  eapm_core u_core (
    .clk, .rst,
    .in_valid(q_valid), .in_ready(q_ready), .in_data(q_w),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .out_rot(rot), .out_trans(trans)
  );

  assign m_tdata = {trans, rot};
endmodule

// File: sv/eapm_fifo.sv
// eapm_fifo: small queue decoupling the input side from the compute pipeline.
// Depends on eapm_pkg.
module eapm_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  eapm_pkg::pose_in_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output eapm_pkg::pose_in_t out_data
);
  eapm_pkg::pose_in_t mem [4];
  logic [1:0] wp, rp;
  logic [2:0] cnt;
  logic wr, rd;

  assign in_ready = cnt != 3'd4;
  assign out_valid = cnt != 3'd0;
  assign wr = in_valid && in_ready;
  assign rd = out_valid && out_ready;
  assign out_data = mem[rp];

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= in_data;
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (wr) wp <= wp + 2'd1;
      if (rd) rp <= rp + 2'd1;
      cnt <= cnt + {2'b0, wr} - {2'b0, rd};
    end
  end
endmodule

// File: sv/eapm_core.sv
// eapm_core: pipelined CORDIC sine/cosine for three angles and the matrix
// products, with an output buffer. Depends on eapm_pkg.
module eapm_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  eapm_pkg::pose_in_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [143:0]       out_rot,
  output logic [95:0]        out_trans
);
  localparam int S = eapm_pkg::Steps;
  localparam int CW = eapm_pkg::CW;
  localparam int D = S + 5;

  logic adv;
  logic [D-1:0] vld;
  logic [95:0] tr [D];
  eapm_pkg::cordic_t cs [3][S+1];
  logic flip [3][S+1];

  // output skid: two-entry buffer
  logic [239:0] ob [2];
  logic [1:0] ocnt;
  logic owp, orp;

  assign adv = (ocnt == 2'd0) || (ocnt == 2'd1 && !vld[D-1]) ||
               (out_ready && ocnt != 2'd0);
  assign in_ready = adv;

  // stage 0: range reduction
  logic signed [15:0] ang [3];
  assign ang[0] = in_data.yaw_angle;
  assign ang[1] = in_data.pitch_angle;
  assign ang[2] = in_data.roll_angle;

  genvar g, k;
  generate
    for (g = 0; g < 3; g++) begin : g_ang
      logic signed [CW-1:0] a0;
      assign a0 = {{(CW-23){ang[g][15]}}, ang[g], 7'b0};
      always_ff @(posedge clk) begin
        if (adv) begin
          cs[g][0].x <= eapm_pkg::GainQ20;
          cs[g][0].y <= '0;
          if (a0 > eapm_pkg::HalfPiQ20) begin
            cs[g][0].z <= a0 - eapm_pkg::PiQ20;
            flip[g][0] <= 1'b1;
          end else if (a0 < -eapm_pkg::HalfPiQ20) begin
            cs[g][0].z <= a0 + eapm_pkg::PiQ20;
            flip[g][0] <= 1'b1;
          end else begin
            cs[g][0].z <= a0;
            flip[g][0] <= 1'b0;
          end
        end
      end
      for (k = 0; k < S; k++) begin : g_it
        eapm_pkg::cordic_t c;
        assign c = cs[g][k];
        always_ff @(posedge clk) begin
          if (adv) begin
            flip[g][k+1] <= flip[g][k];
            if (!c.z[CW-1]) begin
              cs[g][k+1].x <= c.x - (c.y >>> k);
              cs[g][k+1].y <= c.y + (c.x >>> k);
              cs[g][k+1].z <= c.z - eapm_pkg::atan_q20(5'(k));
            end else begin
              cs[g][k+1].x <= c.x + (c.y >>> k);
              cs[g][k+1].y <= c.y - (c.x >>> k);
              cs[g][k+1].z <= c.z + eapm_pkg::atan_q20(5'(k));
            end
          end
        end
      end
    end
  endgenerate

  // stage S+1: signed sin/cos
  logic signed [CW-1:0] sy, cy, sp, cp, sr, cr;
  always_ff @(posedge clk) begin
    if (adv) begin
      sy <= flip[0][S] ? -cs[0][S].y : cs[0][S].y;
      cy <= flip[0][S] ? -cs[0][S].x : cs[0][S].x;
      sp <= flip[1][S] ? -cs[1][S].y : cs[1][S].y;
      cp <= flip[1][S] ? -cs[1][S].x : cs[1][S].x;
      sr <= flip[2][S] ? -cs[2][S].y : cs[2][S].y;
      cr <= flip[2][S] ? -cs[2][S].x : cs[2][S].x;
    end
  end

  // stage S+2: first products
  logic signed [47:0] p_cpcy, p_cpsy, p_crcp, p_srcp, p_crsy, p_crcy, p_srsy, p_srcy;
  logic signed [47:0] p_spcy, p_spsy;
  logic signed [CW-1:0] sp2, sr2, cr2;
  always_ff @(posedge clk) begin
    if (adv) begin
      p_cpcy <= 48'(cp) * 48'(cy);
      p_cpsy <= 48'(cp) * 48'(sy);
      p_crcp <= 48'(cr) * 48'(cp);
      p_srcp <= 48'(sr) * 48'(cp);
      p_crsy <= 48'(cr) * 48'(sy);
      p_crcy <= 48'(cr) * 48'(cy);
      p_srsy <= 48'(sr) * 48'(sy);
      p_srcy <= 48'(sr) * 48'(cy);
      p_spcy <= 48'(sp) * 48'(cy);
      p_spsy <= 48'(sp) * 48'(sy);
      sp2 <= sp;
      sr2 <= sr;
      cr2 <= cr;
    end
  end

  // stage S+3: second-level products
  logic signed [47:0] spcy_r, spsy_r;
  assign spcy_r = (p_spcy + 48'sd524288) >>> 20;
  assign spsy_r = (p_spsy + 48'sd524288) >>> 20;
  logic signed [47:0] q_srspcy, q_crspcy, q_srspsy, q_crspsy;
  logic signed [47:0] h_cpcy, h_cpsy, h_crcp, h_srcp, h_crsy, h_crcy, h_srsy, h_srcy;
  logic signed [CW-1:0] sp3;
  always_ff @(posedge clk) begin
    if (adv) begin
      q_srspcy <= 48'(sr2) * spcy_r;
      q_crspcy <= 48'(cr2) * spcy_r;
      q_srspsy <= 48'(sr2) * spsy_r;
      q_crspsy <= 48'(cr2) * spsy_r;
      h_cpcy <= p_cpcy; h_cpsy <= p_cpsy; h_crcp <= p_crcp; h_srcp <= p_srcp;
      h_crsy <= p_crsy; h_crcy <= p_crcy; h_srsy <= p_srsy; h_srcy <= p_srcy;
      sp3 <= sp2;
    end
  end

  // stage S+4: sums, rounding, saturation
  logic [143:0] rot_d;
  always_ff @(posedge clk) begin
    if (adv) begin
      rot_d[15:0]    <= eapm_pkg::to_q14(h_cpcy);
      rot_d[31:16]   <= eapm_pkg::to_q14(-h_cpsy);
      rot_d[47:32]   <= eapm_pkg::to_q14(48'(sp3) <<< 20);
      rot_d[63:48]   <= eapm_pkg::to_q14(q_srspcy + h_crsy);
      rot_d[79:64]   <= eapm_pkg::to_q14(h_crcy - q_srspsy);
      rot_d[95:80]   <= eapm_pkg::to_q14(-h_srcp);
      rot_d[111:96]  <= eapm_pkg::to_q14(h_srsy - q_crspcy);
      rot_d[127:112] <= eapm_pkg::to_q14(q_crspsy + h_srcy);
      rot_d[143:128] <= eapm_pkg::to_q14(h_crcp);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tr[0] <= {in_data.trans_z, in_data.trans_y, in_data.trans_x};
      for (int i = 1; i < D; i++) tr[i] <= tr[i-1];
    end
  end

  logic opush, opop;
  assign opush = adv && vld[D-1];
  assign opop = out_valid && out_ready;
  assign out_valid = ocnt != 2'd0;
  assign out_rot = ob[orp][143:0];
  assign out_trans = ob[orp][239:144];

  always_ff @(posedge clk) begin
    if (opush) ob[owp] <= {tr[D-1], rot_d};
    if (rst) begin
      vld <= '0;
      ocnt <= '0;
      owp <= 1'b0;
      orp <= 1'b0;
    end else begin
      if (adv) vld <= {vld[D-2:0], in_valid};
      if (opush) owp <= ~owp;
      if (opop) orp <= ~orp;
      ocnt <= ocnt + {1'b0, opush} - {1'b0, opop};
    end
  end
endmodule

// File: sv/eapm_checker.sv
// eapm_checker: port-level assertions for the pose matrix unit, bound to top.
// Depends on euler_angles_to_pose_matrix_unit only through its ports.
module eapm_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [239:0] m_tdata
);
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("out stall");
  a_rot02: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[47:32]) <= 16'sd16384 &&
                  $signed(m_tdata[47:32]) >= -16'sd16384)) else $error("range");
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid) else $error("reset");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> s_tready) else $error("ready after reset");
endmodule

bind euler_angles_to_pose_matrix_unit eapm_checker u_chk (
  .clk, .rst, .s_tready, .m_tvalid, .m_tready, .m_tdata
);
